[hdl/qte_pkg.sv]
// qte_pkg: shared widths, types and the CORDIC angle table for the
// quaternion to Euler angle pipeline. No dependencies.
`timescale 1ns / 1ps

package qte_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int NSTG          = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

	localparam int DW   = 16;        // input component width
	localparam int CW   = 36;        // CORDIC x/y datapath width
	localparam int AW   = 26;        // angle accumulator, degrees * 2^16
	localparam int SW   = 30;        // clamped pitch sine, Q28
	localparam int QB   = 28;        // fraction bits of the product sums
	localparam int NW   = 58;        // radicand width, holds 2^56
	localparam int RW   = NW / 2;    // root width
	localparam int REMW = RW + 3;    // partial remainder width
	localparam int ISQ_STAGES = NW / 2;
	localparam int OW   = 16;        // roll/yaw width
	localparam int PW   = 15;        // pitch width
	localparam int RNDW = AW - 9;    // rounded angle width

	localparam logic signed [AW-1:0]   ACC_P90   = AW'(90 * 65536);
	localparam logic signed [AW-1:0]   ACC_N90   = -AW'(90 * 65536);
	localparam logic signed [AW-1:0]   ACC_HALF  = AW'(256);
	localparam logic signed [RNDW-1:0] ANG_MAX   = RNDW'(23040);
	localparam logic signed [OW-1:0]   PITCH_MAX = OW'(11520);

	typedef logic signed [DW-1:0] qin_t;
	typedef logic signed [CW-1:0] cval_t;
	typedef logic signed [AW-1:0] ang_t;
	typedef logic signed [OW-1:0] deg_t;
	typedef logic signed [SW-1:0] sin_t;

	typedef struct packed {
		cval_t r0;
		cval_t r1;
		cval_t y0;
		cval_t y1;
		sin_t  s;
	} args_t;

	// atan(2^-i) in degrees * 65536
	function automatic ang_t ang_tab(input int i);
		ang_t a;
		case (i)
			0:  a = AW'(2949120);
			1:  a = AW'(1740967);
			2:  a = AW'(919879);
			3:  a = AW'(466945);
			4:  a = AW'(234379);
			5:  a = AW'(117304);
			6:  a = AW'(58666);
			7:  a = AW'(29335);
			8:  a = AW'(14668);
			9:  a = AW'(7334);
			10: a = AW'(3667);
			11: a = AW'(1833);
			12: a = AW'(917);
			13: a = AW'(458);
			14: a = AW'(229);
			15: a = AW'(115);
			16: a = AW'(57);
			17: a = AW'(29);
			18: a = AW'(14);
			19: a = AW'(7);
			20: a = AW'(4);
			21: a = AW'(2);
			22: a = AW'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

[hdl/qte_if.sv]
// qte_in_if / qte_out_if: valid/ready channels for quaternion words and
// Euler angle words. Depends on qte_pkg.
`timescale 1ns / 1ps

interface qte_in_if;
	logic          valid;
	logic          ready;
	qte_pkg::qin_t quat_w;
	qte_pkg::qin_t quat_x;
	qte_pkg::qin_t quat_y;
	qte_pkg::qin_t quat_z;
	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if;
	logic                        valid;
	logic                        ready;
	logic signed [15:0]          roll_deg;
	logic signed [14:0]          pitch_deg;
	logic signed [15:0]          yaw_deg;
	modport source (output valid, roll_deg, pitch_deg, yaw_deg, input ready);
	modport sink   (input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface

[hdl/quaternion_to_euler_angles_top.sv]
// Converts unit quaternions (Q1.14) to ZYX roll, pitch, yaw in degrees * 128.
// One word per cycle enters while the output is not stalled. The path runs
// through the product stages, the bit-per-stage square root, the CORDIC
// stages and an output register. A stalled output holds the whole pipeline;
// nothing is lost or repeated.
// Depends on qte_pkg, qte_if, qte_prod, qte_isqrt, qte_cordic.
`timescale 1ns / 1ps

module quaternion_to_euler_angles_top (
	input  logic      clk,
	input  logic      arst_n,
	qte_in_if.sink    quat,
	qte_out_if.source euler
);

	logic                    en;
	logic                    p_v;
	qte_pkg::args_t          p_args;
	logic [qte_pkg::NW-1:0]  p_n;
	logic                    q_v;
	qte_pkg::args_t          q_args;
	logic [qte_pkg::RW-1:0]  q_root;
	logic                    roll_v, pitch_v, yaw_v;
	qte_pkg::deg_t           roll_a, pitch_a, yaw_a;
	logic                    out_v_q;
	qte_pkg::deg_t           roll_q, yaw_q;
	logic signed [qte_pkg::PW-1:0] pitch_q, pitch_c;

	assign en         = !out_v_q || euler.ready;
	assign quat.ready = en;

	qte_prod u_prod (
		.clk, .arst_n, .en,
		.in_v(quat.valid),
		.w(quat.quat_w), .x(quat.quat_x), .y(quat.quat_y), .z(quat.quat_z),
		.out_v(p_v), .out_args(p_args), .out_n(p_n)
	);

	qte_isqrt u_isqrt (
		.clk, .arst_n, .en,
		.in_v(p_v), .in_args(p_args), .in_n(p_n),
		.out_v(q_v), .out_args(q_args), .out_root(q_root)
	);

	qte_cordic u_roll (
		.clk, .arst_n, .en, .in_v(q_v),
		.y(q_args.r0), .x(q_args.r1),
		.out_v(roll_v), .ang(roll_a)
	);

	qte_cordic u_pitch (
		.clk, .arst_n, .en, .in_v(q_v),
		.y(qte_pkg::CW'(q_args.s)), .x(qte_pkg::CW'({1'b0, q_root})),
		.out_v(pitch_v), .ang(pitch_a)
	);

	qte_cordic u_yaw (
		.clk, .arst_n, .en, .in_v(q_v),
		.y(q_args.y0), .x(q_args.y1),
		.out_v(yaw_v), .ang(yaw_a)
	);

	always_comb begin
		if (pitch_a > qte_pkg::PITCH_MAX) begin
			pitch_c = qte_pkg::PITCH_MAX[qte_pkg::PW-1:0];
		end else if (pitch_a < -qte_pkg::PITCH_MAX) begin
			pitch_c = qte_pkg::PW'(-qte_pkg::PITCH_MAX);
		end else begin
			pitch_c = pitch_a[qte_pkg::PW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= roll_v && pitch_v && yaw_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_q  <= roll_a;
			pitch_q <= pitch_c;
			yaw_q   <= yaw_a;
		end
	end

	assign euler.valid     = out_v_q;
	assign euler.roll_deg  = roll_q;
	assign euler.pitch_deg = pitch_q;
	assign euler.yaw_deg   = yaw_q;

endmodule

[hdl/qte_prod.sv]
// qte_prod: four-stage front end forming the ZYX product sums, the clamped
// pitch sine and the cosine radicand 2^56 - s^2. Depends on qte_pkg.
`timescale 1ns / 1ps

module qte_prod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_v,
	input  qte_pkg::qin_t             w,
	input  qte_pkg::qin_t             x,
	input  qte_pkg::qin_t             y,
	input  qte_pkg::qin_t             z,
	output logic                      out_v,
	output qte_pkg::args_t            out_args,
	output logic [qte_pkg::NW-1:0]    out_n
);

	localparam int PRW = 2 * qte_pkg::DW;
	localparam logic signed [qte_pkg::CW-1:0] ONE_Q = qte_pkg::CW'(1) <<< qte_pkg::QB;
	localparam logic [qte_pkg::NW-1:0] ONE_SQ = qte_pkg::NW'(1) << (2 * qte_pkg::QB);

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [PRW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;
	qte_pkg::args_t args_s2, args_s3, args_s4;
	logic signed [2*qte_pkg::SW-1:0] sq_s3;
	logic [qte_pkg::NW-1:0] n_s4;

	qte_pkg::cval_t sraw;
	qte_pkg::args_t args_d;

	always_comb begin
		args_d.r0 = 2 * (qte_pkg::CW'(wx_s1) + qte_pkg::CW'(yz_s1));
		args_d.r1 = ONE_Q - 2 * (qte_pkg::CW'(xx_s1) + qte_pkg::CW'(yy_s1));
		args_d.y0 = 2 * (qte_pkg::CW'(wz_s1) + qte_pkg::CW'(xy_s1));
		args_d.y1 = ONE_Q - 2 * (qte_pkg::CW'(yy_s1) + qte_pkg::CW'(zz_s1));
		sraw      = 2 * (qte_pkg::CW'(wy_s1) - qte_pkg::CW'(zx_s1));
		if (sraw > ONE_Q) begin
			args_d.s = qte_pkg::SW'(ONE_Q);
		end else if (sraw < -ONE_Q) begin
			args_d.s = -qte_pkg::SW'(ONE_Q);
		end else begin
			args_d.s = qte_pkg::SW'(sraw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1   <= w * x;
			yz_s1   <= y * z;
			xx_s1   <= x * x;
			yy_s1   <= y * y;
			wy_s1   <= w * y;
			zx_s1   <= z * x;
			wz_s1   <= w * z;
			xy_s1   <= x * y;
			zz_s1   <= z * z;
			args_s2 <= args_d;
			args_s3 <= args_s2;
			sq_s3   <= args_s2.s * args_s2.s;
			args_s4 <= args_s3;
			n_s4    <= ONE_SQ - sq_s3[qte_pkg::NW-1:0];
		end
	end

	assign out_v    = v_s4;
	assign out_args = args_s4;
	assign out_n    = n_s4;

endmodule

[hdl/qte_isqrt.sv]
// qte_isqrt: pipelined floor square root, one root bit per stage, with the
// angle arguments carried alongside. Depends on qte_pkg.
`timescale 1ns / 1ps

module qte_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_v,
	input  qte_pkg::args_t            in_args,
	input  logic [qte_pkg::NW-1:0]    in_n,
	output logic                      out_v,
	output qte_pkg::args_t            out_args,
	output logic [qte_pkg::RW-1:0]    out_root
);

	localparam int N = qte_pkg::ISQ_STAGES;

	logic                      v_i   [N];
	qte_pkg::args_t            a_i   [N];
	logic [qte_pkg::NW-1:0]    n_i   [N];
	logic [qte_pkg::REMW-1:0]  rem_i [N];
	logic [qte_pkg::RW-1:0]    q_i   [N];

	logic                      v_s   [N];
	qte_pkg::args_t            a_s   [N];
	logic [qte_pkg::NW-1:0]    n_s   [N];
	logic [qte_pkg::REMW-1:0]  rem_s [N];
	logic [qte_pkg::RW-1:0]    q_s   [N];

	for (genvar k = 0; k < N; k++) begin : g_stg
		logic [qte_pkg::REMW-1:0] r_sh, t;
		logic                     ge;

		if (k == 0) begin : g_first
			assign v_i[k]   = in_v;
			assign a_i[k]   = in_args;
			assign n_i[k]   = in_n;
			assign rem_i[k] = '0;
			assign q_i[k]   = '0;
		end else begin : g_next
			assign v_i[k]   = v_s[k-1];
			assign a_i[k]   = a_s[k-1];
			assign n_i[k]   = n_s[k-1];
			assign rem_i[k] = rem_s[k-1];
			assign q_i[k]   = q_s[k-1];
		end

		always_comb begin
			r_sh = {rem_i[k][qte_pkg::REMW-3:0], n_i[k][qte_pkg::NW-1 -: 2]};
			t    = qte_pkg::REMW'({q_i[k], 2'b01});
			ge   = (r_sh >= t);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_i[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				a_s[k]   <= a_i[k];
				n_s[k]   <= n_i[k] << 2;
				rem_s[k] <= ge ? (r_sh - t) : r_sh;
				q_s[k]   <= {q_i[k][qte_pkg::RW-2:0], ge};
			end
		end
	end

	assign out_v    = v_s[N-1];
	assign out_args = a_s[N-1];
	assign out_root = q_s[N-1];

endmodule

[hdl/qte_cordic.sv]
// qte_cordic: pipelined vectoring CORDIC atan2, result in degrees * 128
// clamped to +/-180. Depends on qte_pkg.
`timescale 1ns / 1ps

module qte_cordic (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  qte_pkg::cval_t  y,
	input  qte_pkg::cval_t  x,
	output logic            out_v,
	output qte_pkg::deg_t   ang
);

	localparam int N = qte_pkg::NSTG;

	logic            v_s    [N+1];
	logic            zero_s [N+1];
	qte_pkg::cval_t  x_s    [N+1];
	qte_pkg::cval_t  y_s    [N+1];
	qte_pkg::ang_t   acc_s  [N+1];
	logic            v_rnd_s;
	qte_pkg::deg_t   ang_rnd_s;

	qte_pkg::cval_t  px, py;
	qte_pkg::ang_t   pacc;
	qte_pkg::ang_t   t;
	logic signed [qte_pkg::RNDW-1:0] rr;
	qte_pkg::deg_t   rc;

	// quadrant pre-rotation
	always_comb begin
		px   = x;
		py   = y;
		pacc = '0;
		if (x < 0) begin
			if (y >= 0) begin
				px   = y;
				py   = -x;
				pacc = qte_pkg::ACC_P90;
			end else begin
				px   = -y;
				py   = x;
				pacc = qte_pkg::ACC_N90;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x == 0) && (y == 0);
			x_s[0]    <= px;
			y_s[0]    <= py;
			acc_s[0]  <= pacc;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1]   <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1]   <= y_s[i] - (x_s[i] >>> i);
					acc_s[i+1] <= acc_s[i] + qte_pkg::ang_tab(i);
				end else begin
					x_s[i+1]   <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1]   <= y_s[i] + (x_s[i] >>> i);
					acc_s[i+1] <= acc_s[i] - qte_pkg::ang_tab(i);
				end
			end
		end
	end

	always_comb begin
		t  = acc_s[N] + qte_pkg::ACC_HALF;
		rr = t[qte_pkg::AW-1:9];
		if (zero_s[N]) begin
			rc = '0;
		end else if (rr > qte_pkg::ANG_MAX) begin
			rc = qte_pkg::OW'(qte_pkg::ANG_MAX);
		end else if (rr < -qte_pkg::ANG_MAX) begin
			rc = -qte_pkg::OW'(qte_pkg::ANG_MAX);
		end else begin
			rc = rr[qte_pkg::OW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_rnd_s <= 1'b0;
		end else if (en) begin
			v_rnd_s <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_rnd_s <= rc;
		end
	end

	assign out_v = v_rnd_s;
	assign ang   = ang_rnd_s;

endmodule

[bench/quaternion_to_euler_angles_top_tb.sv]
// Testbench for quaternion_to_euler_angles_top: directed and random quaternion
// words, a bit-exact angle predictor, and a scoreboard of expected angles.
// Depends on qte_pkg, qte_if and the RTL of the block.
`timescale 1ns / 1ps

module quaternion_to_euler_angles_top_tb;

	typedef struct packed {
		qte_pkg::qin_t w;
		qte_pkg::qin_t x;
		qte_pkg::qin_t y;
		qte_pkg::qin_t z;
	} quat_t;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
	} euler_t;

	localparam longint Q28 = 64'sd1 << 28;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qte_in_if  quat ();
	qte_out_if euler ();

	quaternion_to_euler_angles_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.quat  (quat.sink),
		.euler (euler.source)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	quat_t  pending_q[$];
	euler_t angles_exp[$];
	int     errors = 0;
	bit     hold_off = 0;
	bit     calm = 0;

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint atan2_deg(longint yv, longint xv);
		longint acc, nx, ny;
		int n;
		acc = 0;
		n = (qte_pkg::CORDIC_STAGES < 24) ? qte_pkg::CORDIC_STAGES : 24;
		if (xv == 0 && yv == 0)
			return 0;
		if (xv < 0) begin
			if (yv >= 0) begin
				nx = yv; ny = -xv; acc = 90 * 65536;
			end else begin
				nx = -yv; ny = xv; acc = -90 * 65536;
			end
			xv = nx; yv = ny;
		end
		for (int i = 0; i < n; i++) begin
			if (yv > 0) begin
				nx = xv + floor_shift(yv, i);
				ny = yv - floor_shift(xv, i);
				acc += longint'(qte_pkg::ang_tab(i));
			end else begin
				nx = xv - floor_shift(yv, i);
				ny = yv + floor_shift(xv, i);
				acc -= longint'(qte_pkg::ang_tab(i));
			end
			xv = nx; yv = ny;
		end
		return clip(floor_shift(acc + 256, 9), -23040, 23040);
	endfunction

	function automatic longint floor_sqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic euler_t quat_to_euler(quat_t q);
		longint w, x, y, z, s, c;
		euler_t e;
		w = q.w; x = q.x; y = q.y; z = q.z;
		s = clip(2 * (w * y - z * x), -Q28, Q28);
		c = floor_sqrt(longint'(Q28 * Q28 - s * s));
		e.roll  = 16'(atan2_deg(2 * (w * x + y * z), Q28 - 2 * (x * x + y * y)));
		e.pitch = 15'(clip(atan2_deg(s, c), -11520, 11520));
		e.yaw   = 16'(atan2_deg(2 * (w * z + x * y), Q28 - 2 * (y * y + z * z)));
		return e;
	endfunction

	function automatic qte_pkg::qin_t rand_comp();
		return qte_pkg::qin_t'($urandom_range(32768) - 16384);
	endfunction

	// random unit quaternion, scaled to Q1.14 from a random direction
	function automatic quat_t rand_unit();
		real a, b, c, d, n;
		quat_t q;
		a = real'($urandom_range(2000)) - 1000.0;
		b = real'($urandom_range(2000)) - 1000.0;
		c = real'($urandom_range(2000)) - 1000.0;
		d = real'($urandom_range(2000)) - 1000.0;
		n = $sqrt(a * a + b * b + c * c + d * d);
		if (n < 1.0) begin
			a = 1000.0; n = 1000.0;
		end
		q.w = qte_pkg::qin_t'($rtoi(a / n * 16384.0));
		q.x = qte_pkg::qin_t'($rtoi(b / n * 16384.0));
		q.y = qte_pkg::qin_t'($rtoi(c / n * 16384.0));
		q.z = qte_pkg::qin_t'($rtoi(d / n * 16384.0));
		return q;
	endfunction

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 9);
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat.valid  <= 1'b0;
			quat.quat_w <= '0;
			quat.quat_x <= '0;
			quat.quat_y <= '0;
			quat.quat_z <= '0;
		end else begin
			if (quat.valid && quat.ready) begin
				angles_exp.push_back(quat_to_euler({quat.quat_w, quat.quat_x,
					quat.quat_y, quat.quat_z}));
			end
			if (!quat.valid || quat.ready) begin
				if (pending_q.size() > 0 && !hold_off && !idle_now()) begin
					quat_t q;
					q = pending_q.pop_front();
					quat.valid  <= 1'b1;
					quat.quat_w <= q.w;
					quat.quat_x <= q.x;
					quat.quat_y <= q.y;
					quat.quat_z <= q.z;
				end else begin
					quat.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			euler.ready <= 1'b0;
		end else begin
			if (euler.valid && euler.ready) begin
				if (angles_exp.size() == 0) begin
					$display("%0t: unexpected word roll=%0d pitch=%0d yaw=%0d", $time,
						euler.roll_deg, euler.pitch_deg, euler.yaw_deg);
					errors++;
				end else begin
					euler_t e;
					e = angles_exp.pop_front();
					if (euler.roll_deg !== e.roll) begin
						$display("%0t: roll expected %0d actual %0d", $time, e.roll,
							euler.roll_deg);
						errors++;
					end
					if (euler.pitch_deg !== e.pitch) begin
						$display("%0t: pitch expected %0d actual %0d", $time, e.pitch,
							euler.pitch_deg);
						errors++;
					end
					if (euler.yaw_deg !== e.yaw) begin
						$display("%0t: yaw expected %0d actual %0d", $time, e.yaw,
							euler.yaw_deg);
						errors++;
					end
				end
			end
			euler.ready <= !idle_now();
		end
	end

	task automatic add(int w, int x, int y, int z);
		quat_t q;
		q.w = qte_pkg::qin_t'(w);
		q.x = qte_pkg::qin_t'(x);
		q.y = qte_pkg::qin_t'(y);
		q.z = qte_pkg::qin_t'(z);
		pending_q.push_back(q);
	endtask

	task automatic drain();
		while (pending_q.size() > 0 || quat.valid || angles_exp.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// identity, axes, zero vector, +180 yaw/roll, pitch clamp, extremes
		add(16384, 0, 0, 0);
		add(0, 0, 0, 0);
		add(0, 16384, 0, 0);
		add(0, 0, 16384, 0);
		add(0, 0, 0, 16384);
		add(-16384, 0, 0, 0);
		add(11585, 0, 11585, 0);
		add(11585, 0, -11585, 0);
		add(16384, 0, 16384, 0);
		add(16384, 0, -16384, 0);
		add(-32768, -32768, -32768, -32768);
		add(32767, 32767, 32767, 32767);
		add(-32768, 32767, -32768, 32767);
		add(32767, -32768, 32767, -32768);
		add(16384, 16384, 16384, 16384);
		add(-16384, -16384, -16384, -16384);
		add(8192, 8192, 8192, 8192);
		add(0, 11585, 11585, 0);
		add(0, 0, 11585, 11585);
		add(-1, -1, -1, -1);
		add(1, 1, 1, 1);
		add(-21846, 21845, 0, 0);
		drain();

		// pause until the pipeline is empty, then a burst with no idling
		calm = 1;
		for (int i = 0; i < 120; i++)
			pending_q.push_back(rand_unit());
		while (pending_q.size() > 0)
			@(posedge clk);
		calm = 0;

		for (int i = 0; i < 630; i++) begin
			if ($urandom_range(9) < 8) begin
				pending_q.push_back(rand_unit());
			end else begin
				quat_t q;
				q.w = $urandom_range(1) ? rand_comp() : qte_pkg::qin_t'($urandom);
				q.x = $urandom_range(1) ? rand_comp() : qte_pkg::qin_t'($urandom);
				q.y = $urandom_range(1) ? rand_comp() : qte_pkg::qin_t'($urandom);
				q.z = $urandom_range(1) ? rand_comp() : qte_pkg::qin_t'($urandom);
				pending_q.push_back(q);
			end
			if (i == 300) begin
				while (pending_q.size() > 0)
					@(posedge clk);
				hold_off = 1;
				while (quat.valid || angles_exp.size() > 0)
					@(posedge clk);
				hold_off = 0;
			end
		end
		drain();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("PASS quaternion_to_euler_angles_top");
		else
			$display("FAIL quaternion_to_euler_angles_top");
		$finish;
	end

	initial begin
		#200000;
		$display("FAIL quaternion_to_euler_angles_top");
		$finish;
	end

endmodule
